/* rtl/rfidsfe_pkg.sv */
`default_nettype none

package rfidsfe_pkg;

   localparam int DEFAULT_CHANNELS = 32;

   // per-channel frame buffer
   localparam int BUF_DEPTH = 16;
   localparam int POS_W = 4;
   localparam int FILL_W = 5;

   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_ETX = 8'h03;
   localparam logic [7:0] BYTE_LF = 8'h0a;
   localparam logic [7:0] BYTE_CR = 8'h0d;

   localparam logic [FILL_W-1:0] SHORT_LEN = 5'd14;
   localparam logic [FILL_W-1:0] LONG_LEN = 5'd16;
   localparam logic [POS_W-1:0] LF_POS = 4'd12;

   // beats of one emitted frame: ten payload bytes, then CR, then LF
   localparam int BEAT_W = 4;
   localparam logic [BEAT_W-1:0] PAYLOAD_BEATS = 4'd10;
   localparam logic [BEAT_W-1:0] CR_BEAT = 4'd10;
   localparam logic [BEAT_W-1:0] LF_BEAT = 4'd11;

   typedef struct packed {
      logic take;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_hit;
      logic emit_done;
   } dp_sts_type;

endpackage

`default_nettype wire

/* rtl/rfidsfe_ram.sv */
`default_nettype none

module rfidsfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/rfidsfe_ctrl.sv */
`default_nettype none

module rfidsfe_ctrl
   import rfidsfe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire dp_sts_type  sts,
   output ctl_cmd_type      cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && sts.frame_hit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.take = req_tvalid && (state_ff == ST_IDLE);
   assign cmd.emit = (state_ff == ST_EMIT);

endmodule

`default_nettype wire

/* rtl/rfidsfe_datapath.sv */
`default_nettype none

module rfidsfe_datapath
   import rfidsfe_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [2:0]  board,
   input  wire logic [1:0]  lane,
   input  wire logic [7:0]  rx_byte,
   input  wire logic        break_seen,
   input  wire ctl_cmd_type cmd,
   output dp_sts_type       sts,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [5:0]       out_port,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W = $clog2(CHANNELS * BUF_DEPTH);
   localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

   // receive side
   logic [4:0]        chan;
   logic [CH_W-1:0]   idx;
   logic              keep;
   logic [FILL_W-1:0] cur_fill;
   logic              restart;
   logic [POS_W-1:0]  pos;
   logic [FILL_W-1:0] next_fill;
   logic              stx0_eff;
   logic              hit;
   logic              store;

   logic [FILL_W-1:0] fill_ff [CHANNELS];
   logic              stx0_ff [CHANNELS];
   logic              lf12_ff [CHANNELS];

   // emit side
   logic [CH_W-1:0]   emit_ch_ff;
   logic [5:0]        emit_port_ff;
   logic [BEAT_W-1:0] beat_ff;
   logic              b_vld_ff;
   logic [BEAT_W-1:0] b_beat_ff;
   logic [5:0]        b_port_ff;
   logic              c_vld_ff;
   logic [5:0]        c_port_ff;
   logic [7:0]        c_byte_ff;
   logic              c_last_ff;
   logic              c_free;
   logic              b_move;
   logic              issue;
   logic [7:0]        rd_data;
   logic [7:0]        b_byte;
   logic [POS_W-1:0]  rd_pos;

   assign chan = {board, lane};
   assign idx = CH_W'(chan);
   assign keep = !break_seen && ({2'b00, chan} < CH_LIMIT);
   assign cur_fill = fill_ff[idx];
   // a start byte or a full unmatched buffer begins a new fill
   assign restart = (rx_byte == BYTE_STX) || (cur_fill >= LONG_LEN);
   assign pos = restart ? '0 : cur_fill[POS_W-1:0];
   assign next_fill = {1'b0, pos} + 5'd1;
   assign stx0_eff = (pos == '0) ? (rx_byte == BYTE_STX) : stx0_ff[idx];

   always_comb begin
      hit = 1'b0;
      if (keep && stx0_eff && (rx_byte == BYTE_ETX)) begin
         if (next_fill == SHORT_LEN) begin
            hit = lf12_ff[idx];
         end else if (next_fill == LONG_LEN) begin
            hit = 1'b1;
         end
      end
   end

   assign store = cmd.take && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (store) begin
         fill_ff[idx] <= hit ? '0 : next_fill;
      end
   end

   // flags for byte 0 being a start byte and byte 12 being LF
   always_ff @(posedge clock) begin
      if (store) begin
         if (pos == '0) begin
            stx0_ff[idx] <= (rx_byte == BYTE_STX);
         end
         if (pos == LF_POS) begin
            lf12_ff[idx] <= (rx_byte == BYTE_LF);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && hit) begin
         emit_ch_ff <= idx;
         emit_port_ff <= {1'b0, chan} + 6'd1;
      end
   end

   // issue -> ram read data (b) -> output register (c)
   assign c_free = !c_vld_ff || out_ready;
   assign b_move = b_vld_ff && c_free;
   assign issue = cmd.emit && (!b_vld_ff || b_move);
   assign rd_pos = beat_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         if (issue) begin
            beat_ff <= (beat_ff == LF_BEAT) ? '0 : beat_ff + 4'd1;
         end
         if (issue) begin
            b_vld_ff <= 1'b1;
         end else if (b_move) begin
            b_vld_ff <= 1'b0;
         end
         if (c_free) begin
            c_vld_ff <= b_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_beat_ff <= beat_ff;
         b_port_ff <= emit_port_ff;
      end
      if (b_move) begin
         c_port_ff <= b_port_ff;
         c_byte_ff <= b_byte;
         c_last_ff <= (b_beat_ff == LF_BEAT);
      end
   end

   always_comb begin
      if (b_beat_ff < PAYLOAD_BEATS) begin
         b_byte = rd_data;
      end else if (b_beat_ff == CR_BEAT) begin
         b_byte = BYTE_CR;
      end else begin
         b_byte = BYTE_LF;
      end
   end

   rfidsfe_ram #(
      .WIDTH (8),
      .DEPTH (CHANNELS * BUF_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (ADDR_W'({idx, pos})),
      .wr_data (rx_byte),
      .rd_en   (issue && (beat_ff < PAYLOAD_BEATS)),
      .rd_addr (ADDR_W'({emit_ch_ff, rd_pos})),
      .rd_data (rd_data)
   );

   assign sts.frame_hit = hit;
   assign sts.emit_done = issue && (beat_ff == LF_BEAT);

   assign out_valid = c_vld_ff;
   assign out_port = c_port_ff;
   assign out_byte = c_byte_ff;
   assign out_last = c_last_ff;

endmodule

`default_nettype wire

/* rtl/rfid_serial_frame_extractor_unit.sv */
`default_nettype none

// channel   dir  tdata (lsb first)                       tuser / tlast
// req_      in   board[2:0] lane[4:3] rx_byte[12:5]      tuser: break_seen
// rsp_      out  port_number[5:0] out_byte[13:6]         tlast: last (on LF)
//
// a byte that completes a frame is followed by 12 result beats, ten read from
// the frame buffer ram and then CR and LF, issued one a cycle unless the output
// stalls; the input is closed until the final beat is issued.
// synchronous reset clears fill counts and all control; no clearing pass.
// rsp_tready low stalls the two-entry read/output pipe, and with it the issue.

module rfid_serial_frame_extractor_unit
   import rfidsfe_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // board, lane, rx_byte, 3'b0 pad
   input  wire logic        req_tuser,   // break_seen
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // port_number, out_byte, 2'b0 pad
   output logic             rsp_tlast
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   logic [5:0]  out_port;
   logic [7:0]  out_byte;

   rfidsfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rfidsfe_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .board      (req_tdata[2:0]),
      .lane       (req_tdata[4:3]),
      .rx_byte    (req_tdata[12:5]),
      .break_seen (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_port   (out_port),
      .out_byte   (out_byte),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_byte, out_port};

   // a completed frame closes the input until its beats are issued
   a_hit_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && sts.frame_hit) |=> !req_tready)
      else $error("input still open after frame match");

   // the input reopens right after the final beat is issued
   a_done_reopens: assert property (@(posedge clock) disable iff (reset)
      sts.emit_done |=> req_tready)
      else $error("input not reopened after frame emit");

   // the marked last beat always carries the line feed
   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[13:6] == BYTE_LF))
      else $error("last beat is not a line feed");

endmodule

`default_nettype wire

/* bench/rfid_serial_frame_extractor_unit_test.sv */
module rfid_serial_frame_extractor_unit_test;
   import rfidsfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS = DEFAULT_CHANNELS;
   localparam int RANDOM_ITEMS = 120;
   localparam int IDLE_PCT = 17;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [2:0] board;
      logic [1:0] lane;
      logic [7:0] rx_byte;
      logic       brk;
      logic       hold;   // wait for all outstanding beats before sending
   } uart_byte_type;

   typedef struct packed {
      logic [5:0] port;
      logic [7:0] data;
      logic       last;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // board, lane, rx_byte, pad
   logic        req_tuser = 1'b0;  // break_seen
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // port_number, out_byte, pad
   logic        rsp_tlast;

   uart_byte_type  pending[$];
   uart_byte_type  in_flight;
   frame_beat_type beats_due[$];

   logic [7:0]  frame_buf[CHANNELS][BUF_DEPTH];
   int          fill_lvl[CHANNELS];
   int          sent_count = 0;
   int          item_count = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;
   logic        calm;

   // no idling on either side through a stretch of the run
   assign calm = sent_count >= 70 && sent_count < 110;

   rfid_serial_frame_extractor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // channel byte in, up to twelve frame beats out
   task automatic extract_frame(input uart_byte_type b);
      int             ch;
      int             n;
      frame_beat_type beat;
      if (b.brk) return;
      ch = int'({b.board, b.lane});
      if (ch >= CHANNELS) return;
      n = fill_lvl[ch];
      if (b.rx_byte == BYTE_STX || n >= BUF_DEPTH) n = 0;
      frame_buf[ch][n] = b.rx_byte;
      n++;
      fill_lvl[ch] = n;
      if ((n == SHORT_LEN && frame_buf[ch][0] == BYTE_STX && frame_buf[ch][LF_POS] == BYTE_LF
           && frame_buf[ch][SHORT_LEN-1] == BYTE_ETX)
          || (n == LONG_LEN && frame_buf[ch][0] == BYTE_STX
              && frame_buf[ch][LONG_LEN-1] == BYTE_ETX)) begin
         fill_lvl[ch] = 0;
         beat.port = 6'(ch + 1);
         beat.last = 1'b0;
         for (int i = 1; i <= PAYLOAD_BEATS; i++) begin
            beat.data = frame_buf[ch][i];
            beats_due = {beats_due, beat};
         end
         beat.data = BYTE_CR;
         beats_due = {beats_due, beat};
         beat.data = BYTE_LF;
         beat.last = 1'b1;
         beats_due = {beats_due, beat};
      end
   endtask

   task automatic queue_byte(input logic [2:0] bd, input logic [1:0] ln, input logic [7:0] b,
                             input logic brk, input logic hold);
      uart_byte_type item;
      item = '{board: bd, lane: ln, rx_byte: b, brk: brk, hold: hold};
      pending = {pending, item};
      if (!brk) item_count++;
   endtask

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == BYTE_STX);
      return b;
   endfunction

   // 14 and 16 give well-formed frames, 17 overruns an unmatched buffer
   task automatic queue_frame(input logic [2:0] bd, input logic [1:0] ln, input int len,
                              input logic hold);
      logic [7:0] b;
      queue_byte(bd, ln, BYTE_STX, 1'b0, hold);
      for (int i = 1; i < len; i++) begin
         if ($urandom_range(0, 99) < 8)
            queue_byte(3'($urandom), 2'($urandom), 8'($urandom), 1'($urandom), 1'b0);
         if ($urandom_range(0, 99) < 5)
            queue_byte(bd, ln, 8'($urandom), 1'b1, 1'b0);
         b = body_byte();
         if (len == SHORT_LEN && i == LF_POS) b = BYTE_LF;
         if (len == SHORT_LEN && i == SHORT_LEN - 1) b = BYTE_ETX;
         if (len == LONG_LEN && i == LONG_LEN - 1) b = BYTE_ETX;
         queue_byte(bd, ln, b, 1'b0, 1'b0);
      end
   endtask

   // driver
   always @(posedge clock) begin : drive
      logic send;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            extract_frame(in_flight);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            send = 1'b0;
            if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)
                && !(pending[0].hold && beats_due.size() != 0)) begin
               in_flight = pending.pop_front();
               send = 1'b1;
               req_tdata <= {3'b000, in_flight.rx_byte, in_flight.lane, in_flight.board};
               req_tuser <= in_flight.brk;
            end
            req_tvalid <= send;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin : watch
      frame_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         idle_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (beats_due.size() == 0) begin
               $display("%0t: expected no transaction, actual port %0d byte %02h last %0b",
                        $time, rsp_tdata[5:0], rsp_tdata[13:6], rsp_tlast);
               mismatches++;
            end else begin
               want = beats_due.pop_front();
               if (rsp_tdata[5:0] !== want.port) begin
                  $display("%0t: port_number expected %0d actual %0d", $time, want.port,
                           rsp_tdata[5:0]);
                  mismatches++;
               end
               if (rsp_tdata[13:6] !== want.data) begin
                  $display("%0t: out_byte expected %02h actual %02h", $time, want.data,
                           rsp_tdata[13:6]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         rsp_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] payload[10];
      int         first_random;
      int         pick;
      for (int c = 0; c < CHANNELS; c++) begin
         fill_lvl[c] = 0;
         for (int p = 0; p < BUF_DEPTH; p++) frame_buf[c][p] = '0;
      end

      // long frame on the first channel with edge payload values; bytes 12 and 13
      // look like a short frame's tail but 13 is not ETX, so only the long check hits
      payload = '{8'hff, 8'h00, 8'h80, 8'h7f, 8'h55, 8'haa, 8'h01, 8'hfe, 8'h03, 8'h0a};
      queue_byte(3'd7, 2'd3, 8'h00, 1'b0, 1'b0);
      queue_byte(3'd0, 2'd0, BYTE_STX, 1'b0, 1'b0);
      for (int i = 0; i < 10; i++) begin
         queue_byte(3'd0, 2'd0, payload[i], 1'b0, 1'b0);
         // a break-flagged STX must not restart the fill
         if (i == 4) queue_byte(3'd0, 2'd0, BYTE_STX, 1'b1, 1'b0);
      end
      queue_byte(3'd0, 2'd0, BYTE_CR, 1'b0, 1'b0);
      queue_byte(3'd0, 2'd0, BYTE_LF, 1'b0, 1'b0);
      queue_byte(3'd0, 2'd0, 8'h04, 1'b0, 1'b0);
      queue_byte(3'd0, 2'd0, 8'h99, 1'b0, 1'b0);
      queue_byte(3'd0, 2'd0, BYTE_ETX, 1'b0, 1'b0);

      // first random frame on the highest channel, sent only once the bus is drained
      first_random = item_count;
      queue_frame(3'd7, 2'd3, SHORT_LEN, 1'b1);
      while (item_count - first_random < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            queue_frame(3'($urandom), 2'($urandom), SHORT_LEN, $urandom_range(0, 99) < 15);
         else if (pick < 75)
            queue_frame(3'($urandom), 2'($urandom), LONG_LEN, $urandom_range(0, 99) < 15);
         else if (pick < 85)
            queue_frame(3'($urandom), 2'($urandom), LONG_LEN + 1, 1'b0);
         else
            repeat ($urandom_range(1, 4))
               queue_byte(3'($urandom), 2'($urandom), 8'($urandom), 1'($urandom), 1'b0);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid) @(posedge clock);
      while (beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
